// ===== design/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH_DEFAULT          = 16;
   localparam int PRIORITY_WIDTH_DEFAULT = 16;

   localparam int PRIO_FIELD_WIDTH  = 16;
   localparam int COUNT_FIELD_WIDTH = 5;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_POP    = 2'd1,
      ACT_EXACT  = 2'd2,
      ACT_ABOVE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOMATCH = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      action_type                  action;
      logic [PRIO_FIELD_WIDTH-1:0] priority_req;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic [PRIO_FIELD_WIDTH-1:0]  removed_priority;
      logic [COUNT_FIELD_WIDTH-1:0] entry_count;
   } rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic       capture;
      logic       apply;
      action_type act;
   } cell_ctl_type;

   // compare flags a cell shows its neighbours
   typedef struct packed {
      logic ge;
      logic gt;
   } cell_flag_type;

endpackage

// ===== design/spq_cell.sv =====
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic [PRIORITY_WIDTH-1:0] prio,
   input  logic                      valid,
   input  logic [PRIORITY_WIDTH-1:0] prev_entry,
   input  logic [PRIORITY_WIDTH-1:0] next_entry,
   input  cell_flag_type             prev_flags,
   input  cell_flag_type             next_flags,
   output logic [PRIORITY_WIDTH-1:0] entry,
   output cell_flag_type             flags,
   output logic                      take
);

   logic [PRIORITY_WIDTH-1:0] entry_ff;
   logic [PRIORITY_WIDTH-1:0] entry_in;
   cell_flag_type             flags_ff;

   assign entry = entry_ff;
   assign flags = flags_ff;

   // this cell holds the entry that an exact or above removal deletes (never on pop)
   always_comb begin
      case (ctl.act)
         ACT_EXACT: take = flags_ff.ge & ~flags_ff.gt & prev_flags.gt;
         ACT_ABOVE: take = flags_ff.ge & ~next_flags.ge;
         default:   take = 1'b0;
      endcase
   end

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.act)
         ACT_INSERT: begin
            if (!flags_ff.ge) begin
               entry_in = prev_flags.ge ? prio : prev_entry;
            end
         end
         ACT_POP: entry_in = next_entry;
         ACT_EXACT: begin
            if (!flags_ff.gt) begin
               entry_in = next_entry;
            end
         end
         ACT_ABOVE: begin
            if (!next_flags.ge) begin
               entry_in = next_entry;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (ctl.capture) begin
         flags_ff.ge <= valid & (entry_ff >= prio);
         flags_ff.gt <= valid & (entry_ff > prio);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.apply) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== design/sorted_priority_queue_unit.sv =====
// Channel   Ports                      Handshake
// request   req_data (req_type)        taken at a clock edge with start high, busy low
// response  rsp_data (rsp_type)        one cycle, marked by rsp_strobe, no back-pressure
//
// At acceptance every cell compares its entry with the priority; in the next cycle
// (busy high) the row of cells shifts in one step on success and the response is
// registered; rsp_strobe rises in the cycle after, when start is taken again.
// Synchronous reset empties the queue; entry contents are left as they are.
// The receiver cannot stall the block, so nothing waits on the response side.
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int DEPTH          = DEPTH_DEFAULT,
   parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                 state_ff;
   action_type                act_ff;
   logic [PRIORITY_WIDTH-1:0] prio_ff;
   logic [CW-1:0]             count_ff;
   logic                      rsp_strobe_ff;
   rsp_type                   rsp_ff;

   logic                      accept;
   logic [PRIORITY_WIDTH-1:0] prio_in;
   cell_ctl_type              ctl;
   logic                      full;
   logic                      empty;
   logic                      hit;
   logic                      ok;
   logic [PRIORITY_WIDTH-1:0] removed;
   status_type                status;
   logic [CW-1:0]             count_in;

   logic [PRIORITY_WIDTH-1:0] entries [DEPTH];
   cell_flag_type             flags   [DEPTH];
   logic [DEPTH-1:0]          take;
   logic [DEPTH-1:0]          valid;

   assign busy       = (state_ff == S_EXEC);
   assign accept     = start & ~busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign prio_in    = PRIORITY_WIDTH'(req_data.priority_req);

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign hit   = |take;

   assign ctl.capture = accept;
   assign ctl.apply   = busy & ok;
   assign ctl.act     = busy ? act_ff : req_data.action;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [PRIORITY_WIDTH-1:0] prev_entry;
      logic [PRIORITY_WIDTH-1:0] next_entry;
      cell_flag_type             prev_flags;
      cell_flag_type             next_flags;

      assign valid[g] = (count_ff > CW'(g));

      if (g == 0) begin : g_head
         assign prev_entry = entries[0];
         assign prev_flags = '{ge: 1'b1, gt: 1'b1};
      end else begin : g_body
         assign prev_entry = entries[g-1];
         assign prev_flags = flags[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_entry = entries[DEPTH-1];
         assign next_flags = '{ge: 1'b0, gt: 1'b0};
      end else begin : g_inner
         assign next_entry = entries[g+1];
         assign next_flags = flags[g+1];
      end

      spq_cell #(
         .PRIORITY_WIDTH (PRIORITY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prio       (busy ? prio_ff : prio_in),
         .valid      (valid[g]),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .prev_flags (prev_flags),
         .next_flags (next_flags),
         .entry      (entries[g]),
         .flags      (flags[g]),
         .take       (take[g])
      );
   end

   always_comb begin
      ok       = 1'b0;
      status   = ST_DONE;
      removed  = '0;
      count_in = count_ff;
      if (act_ff == ACT_INSERT) begin
         if (full) begin
            status = ST_FULL;
         end else begin
            ok       = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end else if (empty) begin
         status = ST_EMPTY;
      end else if (act_ff == ACT_POP) begin
         ok       = 1'b1;
         removed  = entries[0];
         count_in = count_ff - 1'b1;
      end else if (hit) begin
         ok       = 1'b1;
         count_in = count_ff - 1'b1;
         for (int i = 0; i < DEPTH; i++) begin
            removed = removed | (take[i] ? entries[i] : '0);
         end
      end else begin
         status = ST_NOMATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff   <= req_data.action;
                  prio_ff  <= prio_in;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               count_ff                  <= count_in;
               rsp_strobe_ff             <= 1'b1;
               rsp_ff.status             <= status;
               rsp_ff.removed_priority   <= PRIO_FIELD_WIDTH'(removed);
               rsp_ff.entry_count        <= COUNT_FIELD_WIDTH'(count_in);
               state_ff                  <= S_IDLE;
            end
         endcase
      end
   end

endmodule
